// ----- rtl/block_min_max_mean_counts_core_macros.svh -----
// ----------------------------------------------------------------------------
// block min/max/mean statistics: assertion macros
// shared property forms for the core checks
// ----------------------------------------------------------------------------
`ifndef BLOCK_MIN_MAX_MEAN_COUNTS_CORE_MACROS_SVH
`define BLOCK_MIN_MAX_MEAN_COUNTS_CORE_MACROS_SVH

// same-cycle implication
`define BMMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bmmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmmm_pkg
// types and fixed constants of the block min/max/mean statistics core
// ----------------------------------------------------------------------------
`default_nettype none

package bmmm_pkg;

  // width of the result count fields
  localparam int COUNT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/block_min_max_mean_counts_core.sv -----
// ----------------------------------------------------------------------------
// block_min_max_mean_counts_core
// block statistics: max, min, truncated mean and four rescan counts
// ----------------------------------------------------------------------------
// A sample is taken at each clock edge with start high and busy low, one per
// cycle, until the sample marked last. Up to MAX_SAMPLES samples are stored;
// later ones are dropped and flag overflow. After the closing sample busy
// stays high while the serial divider works through the sum one bit at a
// time, and then while the store is rescanned one entry per cycle through its
// single read port. The result comes with done high for exactly one cycle;
// the receiver must take it then, as it cannot be held.
`default_nettype none

`include "block_min_max_mean_counts_core_macros.svh"

module block_min_max_mean_counts_core #(
  parameter int MAX_SAMPLES = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          last,
  output logic                               done,
  output logic signed [SAMPLE_BITS-1:0]      maximum,
  output logic signed [SAMPLE_BITS-1:0]      minimum,
  output logic signed [SAMPLE_BITS-1:0]      mean,
  output logic [bmmm_pkg::COUNT_W-1:0]       count_at_max,
  output logic [bmmm_pkg::COUNT_W-1:0]       count_at_min,
  output logic [bmmm_pkg::COUNT_W-1:0]       count_above,
  output logic [bmmm_pkg::COUNT_W-1:0]       count_below,
  output logic                               overflow
);

  import bmmm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] store [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          rd_valid;
  logic [CNT_W-1:0]              scan_idx;
  logic                          scan_issue;

  logic [CNT_W-1:0]              count;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic [SUM_W-1:0]              run_sum;
  logic [SUM_W-1:0]              sum_next;
  logic                          dropped;
  logic signed [SAMPLE_BITS-1:0] mean_reg;
  logic [COUNT_W-1:0]            n_max, n_min, n_above, n_below;

  logic                          accept;
  logic                          has_room;
  logic                          div_start;
  logic                          div_done;
  logic [SUM_W-1:0]              sum_mag;
  logic [SUM_W-1:0]              div_q;
  logic [SUM_W-1:0]              q_signed;

  assign busy       = state != S_IDLE;
  assign accept     = start && !busy;
  assign has_room   = count < CNT_W'(MAX_SAMPLES);
  assign sum_next   = run_sum + {{CNT_W{sample[SAMPLE_BITS-1]}}, sample};
  assign scan_issue = (state == S_SCAN) && (scan_idx < count);
  assign div_start  = state == S_PREP;
  assign sum_mag    = run_sum[SUM_W-1] ? (~run_sum + 1'b1) : run_sum;
  assign q_signed   = run_sum[SUM_W-1] ? (~div_q + 1'b1) : div_q;

  bmmm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  // sample store
  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      store[count[ADDR_W-1:0]] <= sample;
    end
    rd_data <= store[scan_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      run_max  <= '0;
      run_min  <= '0;
      run_sum  <= '0;
      dropped  <= 1'b0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
      scan_idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (has_room) begin
              if (count == '0) begin
                run_max <= sample;
                run_min <= sample;
              end else begin
                if (sample > run_max) run_max <= sample;
                if (sample < run_min) run_min <= sample;
              end
              run_sum <= sum_next;
              count   <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (last) state <= S_PREP;
          end
        end
        S_PREP: begin
          scan_idx <= '0;
          rd_valid <= 1'b0;
          n_max    <= '0;
          n_min    <= '0;
          n_above  <= '0;
          n_below  <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean_reg <= q_signed[SAMPLE_BITS-1:0];
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= scan_issue;
          if (scan_issue) scan_idx <= scan_idx + 1'b1;
          if (rd_valid) begin
            if (rd_data == run_max) n_max <= n_max + 1'b1;
            if (rd_data == run_min) n_min <= n_min + 1'b1;
            if (rd_data > mean_reg) n_above <= n_above + 1'b1;
            else if (rd_data < mean_reg) n_below <= n_below + 1'b1;
          end
          if (!scan_issue && !rd_valid) begin
            maximum      <= run_max;
            minimum      <= run_min;
            mean         <= mean_reg;
            count_at_max <= n_max;
            count_at_min <= n_min;
            count_above  <= n_above;
            count_below  <= n_below;
            overflow     <= dropped;
            done         <= 1'b1;
            count        <= '0;
            run_max      <= '0;
            run_min      <= '0;
            run_sum      <= '0;
            dropped      <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BMMM_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `BMMM_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `BMMM_ASSERT_NEXT(a_last_busy, clk, rst, accept && last, busy, "closing transfer did not start work")
  `BMMM_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(MAX_SAMPLES), "store count past capacity")

endmodule

`default_nettype wire

// ----- rtl/bmmm_div.sv -----
// ----------------------------------------------------------------------------
// bmmm_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bmmm_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  import bmmm_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [STEP_W-1:0]    steps;
  logic                 running;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [DIVISOR_W:0]   diff;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        steps    <= STEP_W'(DIVIDEND_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        rem      <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        steps    <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/bmmm_stats_checker.sv -----
// ----------------------------------------------------------------------------
// bmmm_stats_checker
// Watches the sample and result channels of the block statistics core. It
// keeps its own copy of the store, running max/min/sum and drop flag, works
// out the expected statistics when a block closes, and compares every result
// field by field against the oldest expected block.
// ----------------------------------------------------------------------------
module bmmm_stats_checker #(
  parameter int MAX_SAMPLES = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          last,
  input  wire logic                          done,
  input  wire logic signed [SAMPLE_BITS-1:0] maximum,
  input  wire logic signed [SAMPLE_BITS-1:0] minimum,
  input  wire logic signed [SAMPLE_BITS-1:0] mean,
  input  wire logic [bmmm_pkg::COUNT_W-1:0]  count_at_max,
  input  wire logic [bmmm_pkg::COUNT_W-1:0]  count_at_min,
  input  wire logic [bmmm_pkg::COUNT_W-1:0]  count_above,
  input  wire logic [bmmm_pkg::COUNT_W-1:0]  count_below,
  input  wire logic                          overflow,
  output int                                 errors,
  output int                                 pending
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [bmmm_pkg::COUNT_W-1:0]  at_max;
    logic [bmmm_pkg::COUNT_W-1:0]  at_min;
    logic [bmmm_pkg::COUNT_W-1:0]  above;
    logic [bmmm_pkg::COUNT_W-1:0]  below;
    logic                          overflow;
  } block_stats_t;

  block_stats_t                  block_stats_q[$];
  logic signed [SAMPLE_BITS-1:0] kept[MAX_SAMPLES];
  int                            kept_n = 0;
  logic signed [SAMPLE_BITS-1:0] run_max = '0;
  logic signed [SAMPLE_BITS-1:0] run_min = '0;
  longint                        run_sum = 0;
  logic                          dropped = 1'b0;
  int                            mismatch_n = 0;
  int                            waiting_n = 0;

  assign errors  = mismatch_n;
  assign pending = waiting_n;

  function automatic void clear_block();
    kept_n  = 0;
    run_max = '0;
    run_min = '0;
    run_sum = 0;
    dropped = 1'b0;
  endfunction

  // fold one sample into the block; closing sample queues the block stats
  function automatic void absorb_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                        input logic l);
    block_stats_t                 st;
    longint                       avg;
    logic [bmmm_pkg::COUNT_W-1:0] n_max, n_min, n_above, n_below;
    if (kept_n < MAX_SAMPLES) begin
      if (kept_n == 0) begin
        run_max = s;
        run_min = s;
      end else begin
        if (s > run_max) run_max = s;
        if (s < run_min) run_min = s;
      end
      run_sum += s;
      kept[kept_n] = s;
      kept_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!l) return;
    avg     = (kept_n != 0) ? run_sum / kept_n : 0;
    n_max   = '0;
    n_min   = '0;
    n_above = '0;
    n_below = '0;
    for (int i = 0; i < kept_n; i++) begin
      if (kept[i] == run_max) n_max++;
      if (kept[i] == run_min) n_min++;
      if (kept[i] > avg) n_above++;
      else if (kept[i] < avg) n_below++;
    end
    st.maximum  = run_max;
    st.minimum  = run_min;
    st.mean     = avg[SAMPLE_BITS-1:0];
    st.at_max   = n_max;
    st.at_min   = n_min;
    st.above    = n_above;
    st.below    = n_below;
    st.overflow = dropped;
    block_stats_q.push_back(st);
    clear_block();
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [31:0] exp_v,
                                      input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_n++;
    end
  endfunction

  always @(posedge clk) begin
    block_stats_t st;
    if (rst) begin
      clear_block();
      block_stats_q.delete();
    end else begin
      // result transfer first: a block closing at this edge is a later one
      if (done) begin
        if (block_stats_q.size() == 0) begin
          $error("result with no block pending");
          mismatch_n++;
        end else begin
          st = block_stats_q.pop_front();
          check_field("maximum", st.maximum, maximum);
          check_field("minimum", st.minimum, minimum);
          check_field("mean", st.mean, mean);
          check_field("count_at_max", st.at_max, count_at_max);
          check_field("count_at_min", st.at_min, count_at_min);
          check_field("count_above", st.above, count_above);
          check_field("count_below", st.below, count_below);
          check_field("overflow", st.overflow, overflow);
        end
      end
      if (start && !busy) absorb_sample(sample, last);
    end
    waiting_n = block_stats_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Block statistics core test: directed blocks for the value extremes, mean
// truncation toward zero and equal max/min, then random blocks of varied
// length and value mix, including blocks that overrun the sample store. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SB        = 16;
  localparam int CAP       = 32;
  localparam int N_RANDOM  = 1200;
  localparam int IDLE_MAX  = 2000;
  localparam int END_WAIT  = 100;

  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EDGE} sample_mix_t;

  logic                          clk;
  logic                          rst    = 1'b1;
  logic                          start  = 1'b0;
  logic signed [SB-1:0]          sample = '0;
  logic                          last   = 1'b0;
  logic                          busy;
  logic                          done;
  logic signed [SB-1:0]          maximum, minimum, mean;
  logic [bmmm_pkg::COUNT_W-1:0]  count_at_max, count_at_min, count_above, count_below;
  logic                          overflow;
  int                            errors, pending;

  bit gaps_on     = 1'b1;
  int idle_cycles = 0;
  int n_samples   = 0;
  int n_blocks    = 0;
  int n_full      = 0;

  // directed blocks, flattened
  int dir_vals[18] = '{32767, -32768, -32768, 32767, -3, -2, 7, 7, 7,
                       0, -1, 1, 21845, -21846, 1, 1, 2, 2};
  int dir_lens[7]  = '{1, 1, 2, 2, 3, 5, 4};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  block_min_max_mean_counts_core #(
    .MAX_SAMPLES(CAP),
    .SAMPLE_BITS(SB)
  ) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample(sample), .last(last), .done(done),
    .maximum(maximum), .minimum(minimum), .mean(mean),
    .count_at_max(count_at_max), .count_at_min(count_at_min),
    .count_above(count_above), .count_below(count_below),
    .overflow(overflow)
  );

  bmmm_stats_checker #(
    .MAX_SAMPLES(CAP),
    .SAMPLE_BITS(SB)
  ) stats_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample(sample), .last(last), .done(done),
    .maximum(maximum), .minimum(minimum), .mean(mean),
    .count_at_max(count_at_max), .count_at_min(count_at_min),
    .count_above(count_above), .count_below(count_below),
    .overflow(overflow), .errors(errors), .pending(pending)
  );

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_MAX) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic logic signed [SB-1:0] pick_sample(input sample_mix_t mix);
    logic signed [SB-1:0] s;
    case (mix)
      MIX_FULL:   s = SB'($urandom);
      MIX_NARROW: s = SB'($urandom_range(0, 8) - 4);
      default: begin
        case ($urandom_range(0, 5))
          0:       s = 16'h7FFF;
          1:       s = 16'h8000;
          2:       s = 16'h7FFE;
          3:       s = 16'h8001;
          4:       s = 16'h0000;
          default: s = 16'hFFFF;
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic send_item(input logic signed [SB-1:0] s, input logic l);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      start  <= 1'b0;
      sample <= SB'($urandom);
      last   <= 1'($urandom);
      @(negedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    last   <= l;
    do @(posedge clk); while (busy);
    n_samples++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int k, len, n_rand, blk;
    sample_mix_t mix;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    k = 0;
    foreach (dir_lens[b]) begin
      for (int j = 0; j < dir_lens[b]; j++) begin
        send_item(SB'(dir_vals[k]), j == dir_lens[b] - 1);
        k++;
      end
      n_blocks++;
    end

    n_rand = 0;
    blk    = 0;
    while (n_rand < N_RANDOM) begin
      if (blk == 0) begin
        len = CAP + 2;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:9]:   len = $urandom_range(CAP + 1, CAP + 8);
          [10:24]: len = $urandom_range(9, CAP);
          default: len = $urandom_range(1, 8);
        endcase
      end
      mix     = sample_mix_t'($urandom_range(0, 2));
      gaps_on = !(n_rand >= 400 && n_rand < 700);
      if (blk % 40 == 20) drain();
      for (int j = 0; j < len; j++) send_item(pick_sample(mix), j == len - 1);
      if (len > CAP) n_full++;
      n_rand += len;
      n_blocks++;
      blk++;
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d samples in %0d blocks, %0d of them past store capacity",
             n_samples, n_blocks, n_full);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
